FILE: hdl/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg: shared types and constants of the UTF-8 decoder
// Item layouts of both channels, result kinds and the strict-decoding limits.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int unsigned CP_W = 21;

  typedef enum logic [1:0] {
    KIND_CODE_POINT = 2'd0,
    KIND_END_OK     = 2'd1,
    KIND_ILLEGAL    = 2'd2,
    KIND_EXHAUSTED  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    kind_e           kind;
    logic            last_of_run;
  } out_item_t;

  // Results caused by one byte transfer: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } res_bundle_t;

  localparam logic [7:0] CONT_MIN     = 8'h80;
  localparam logic [7:0] CONT_MAX     = 8'hBF;
  localparam logic [7:0] LEAD_MIN     = 8'hC2;
  localparam logic [7:0] LEAD_MAX     = 8'hF4;
  localparam logic [7:0] LEAD_E0      = 8'hE0;
  localparam logic [7:0] LEAD_ED      = 8'hED;
  localparam logic [7:0] LEAD_F0      = 8'hF0;
  localparam logic [7:0] LEAD_F4      = 8'hF4;
  localparam logic [7:0] E0_SECOND_MIN = 8'hA0;
  localparam logic [7:0] ED_SECOND_MAX = 8'h9F;
  localparam logic [7:0] F0_SECOND_MIN = 8'h90;
  localparam logic [7:0] F4_SECOND_MAX = 8'h8F;
  localparam logic [2:0] MAX_EXTRA     = 3'd3;

  // Continuation bytes announced by a lead byte.
  function automatic logic [2:0] extra_for_lead(input logic [7:0] b);
    logic [2:0] e;
    if (b < 8'hC0)      e = 3'd0;
    else if (b < 8'hE0) e = 3'd1;
    else if (b < 8'hF0) e = 3'd2;
    else if (b < 8'hF8) e = 3'd3;
    else if (b < 8'hFC) e = 3'd4;
    else                e = 3'd5;
    return e;
  endfunction

endpackage

FILE: hdl/u8dec_if.sv
// ----------------------------------------------------------------------------
// u8dec_if: valid/ready channels of the UTF-8 decoder
// One interface for the byte stream, one for the result stream.
// ----------------------------------------------------------------------------
interface u8dec_in_if;
  logic               valid;
  logic               ready;
  u8dec_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface u8dec_out_if;
  logic                valid;
  logic                ready;
  u8dec_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/utf8_to_utf32_decoder_unit.sv
// A result is registered into the result queue at the transfer of the byte that causes it.
// Throughput: one byte per cycle while the result queue has room, which needs the results
//   to be taken; a final byte that yields a code point and the end-ok status queues two
//   results in the three-entry result queue, which holds ready low while more than one result waits.
// Reset: asynchronous, active low; clears the sequence state, the drop flag and the queue.
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder_unit: strict streaming UTF-8 to code point decoder
// One byte per transfer in; code points and end statuses out.
// ----------------------------------------------------------------------------
module utf8_to_utf32_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8dec_in_if.sink    in_i,
  u8dec_out_if.source out_o
);
  import u8dec_pkg::*;

  res_bundle_t res;
  logic        room;
  logic        accept;
  logic        pop;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;
  assign pop        = out_o.valid && out_o.ready;

  u8dec_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_i.payload),
    .res_o    (res)
  );

  u8dec_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res),
    .pop_i   (pop),
    .room_o  (room),
    .valid_o (out_o.valid),
    .head_o  (out_o.payload)
  );

endmodule

FILE: hdl/u8dec_core.sv
// ----------------------------------------------------------------------------
// u8dec_core: sequence state and per-byte decode
// Updates the open-sequence state on each byte transfer and forms the
// zero, one or two results that the byte causes.
// ----------------------------------------------------------------------------
module u8dec_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  u8dec_pkg::in_item_t    item_i,
  output u8dec_pkg::res_bundle_t res_o
);
  import u8dec_pkg::*;

  logic [CP_W-1:0] partial_q, partial_d;
  logic [2:0]      need_q, need_d;
  logic [7:0]      lead_q, lead_d;
  logic            second_q, second_d;
  logic            bad_q, bad_d;
  logic            disc_q, disc_d;

  always_comb begin
    logic [7:0]      b;
    logic            eos;
    logic [2:0]      extra;
    logic [CP_W-1:0] pv;
    logic [2:0]      nd;
    logic            bad;

    b     = item_i.byte_in;
    eos   = item_i.end_of_string;
    extra = extra_for_lead(b);
    pv    = partial_q;
    nd    = need_q;
    bad   = bad_q;

    partial_d = partial_q;
    need_d    = need_q;
    lead_d    = lead_q;
    second_d  = second_q;
    bad_d     = bad_q;
    disc_d    = disc_q;
    res_o     = '0;

    if (accept_i) begin
      if (disc_q) begin
        // drop bytes through the end of the string
        if (eos) disc_d = 1'b0;
      end else begin
        if (need_q == 3'd0) begin
          lead_d   = b;
          bad      = (b >= CONT_MIN && b < LEAD_MIN) || (b > LEAD_MAX) || (extra > MAX_EXTRA);
          pv       = CP_W'(b & (8'h7F >> extra));
          nd       = extra;
          second_d = (extra != 3'd0);
        end else begin
          if (b < CONT_MIN || b > CONT_MAX) bad = 1'b1;
          if (second_q) begin
            if (lead_q == LEAD_E0 && b < E0_SECOND_MIN) bad = 1'b1;
            if (lead_q == LEAD_ED && b > ED_SECOND_MAX) bad = 1'b1;
            if (lead_q == LEAD_F0 && b < F0_SECOND_MIN) bad = 1'b1;
            if (lead_q == LEAD_F4 && b > F4_SECOND_MAX) bad = 1'b1;
            second_d = 1'b0;
          end
          pv = {partial_q[CP_W-7:0], b[5:0]};
          nd = need_q - 3'd1;
        end
        partial_d = pv;
        need_d    = nd;
        bad_d     = bad;

        if (nd == 3'd0 || eos) begin
          // sequence closes here: clear it whatever the outcome
          partial_d = '0;
          need_d    = 3'd0;
          lead_d    = 8'h00;
          second_d  = 1'b0;
          bad_d     = 1'b0;
          res_o.count = 2'd1;
          res_o.first.last_of_run = 1'b1;
          if (nd != 3'd0) begin
            res_o.first.kind = KIND_EXHAUSTED;
          end else if (bad) begin
            res_o.first.kind = KIND_ILLEGAL;
            disc_d = !eos;
          end else begin
            res_o.first.kind       = KIND_CODE_POINT;
            res_o.first.code_point = pv;
            if (eos) begin
              res_o.count = 2'd2;
              res_o.first.last_of_run  = 1'b0;
              res_o.second.kind        = KIND_END_OK;
              res_o.second.last_of_run = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      need_q    <= 3'd0;
      lead_q    <= 8'h00;
      second_q  <= 1'b0;
      bad_q     <= 1'b0;
      disc_q    <= 1'b0;
    end else begin
      partial_q <= partial_d;
      need_q    <= need_d;
      lead_q    <= lead_d;
      second_q  <= second_d;
      bad_q     <= bad_d;
      disc_q    <= disc_d;
    end
  end

endmodule

FILE: hdl/u8dec_res_fifo.sv
// ----------------------------------------------------------------------------
// u8dec_res_fifo: three-entry result queue
// Takes up to two results per cycle and hands out one per transfer.
// ----------------------------------------------------------------------------
module u8dec_res_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  u8dec_pkg::res_bundle_t push_i,
  input  logic                   pop_i,
  output logic                   room_o,
  output logic                   valid_o,
  output u8dec_pkg::out_item_t   head_o
);
  import u8dec_pkg::*;

  localparam int unsigned DEPTH = 3;

  out_item_t  mem_q [DEPTH];
  logic [1:0] wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] wr_next;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'(DEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign wr_next = ptr_inc(wr_q);
  // room for a two-result byte
  assign room_o  = (cnt_q <= 2'd1);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    case (push_i.count)
      2'd1:    wr_d = wr_next;
      2'd2:    wr_d = ptr_inc(wr_next);
      default: wr_d = wr_q;
    endcase
    if (pop_i) rd_d = ptr_inc(rd_q);
    cnt_d = cnt_q + push_i.count - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (push_i.count != 2'd0 && wr_q == 2'(i)) mem_q[i] <= push_i.first;
      if (push_i.count == 2'd2 && wr_next == 2'(i)) mem_q[i] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: tb/utf8_to_utf32_decoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder_unit_tb: self-checking bench for the UTF-8 decoder
// Feeds byte strings (legal text, limit-breaking leads, cut-off and garbled
// strings, raw noise) through the byte channel and compares every result
// against a cycle-free decoder kept in the bench.
// ----------------------------------------------------------------------------
module utf8_to_utf32_decoder_unit_tb;
  import u8dec_pkg::*;

  logic clk_i;
  logic rst_ni;

  u8dec_in_if  byte_if ();
  u8dec_out_if res_if ();

  utf8_to_utf32_decoder_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (res_if)
  );

  // Stimulus and expectations
  in_item_t    byte_stream[$];
  out_item_t   due_results[$];

  // Decoder state mirrored in the bench
  logic [CP_W-1:0] cp_acc;
  logic [2:0]      need_cnt;
  logic [7:0]      lead_q;
  logic            second_q;
  logic            bad_q;
  logic            dropping;

  // Flow control
  bit          byte_taken;
  bit          calm;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned rx_hold;
  int unsigned hold_requests;
  int unsigned hold_served;

  // Bookkeeping
  int unsigned errors;
  int unsigned bytes_queued;
  int unsigned decoded_bytes;
  int unsigned dropped_bytes;
  int unsigned kind_count[4];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  function automatic void expect_result(input logic [CP_W-1:0] cp, input kind_e k,
                                        input logic last);
    out_item_t r;
    r.code_point  = cp;
    r.kind        = k;
    r.last_of_run = last;
    due_results.push_back(r);
  endfunction

  function automatic void reset_sequence();
    cp_acc   = '0;
    need_cnt = '0;
    lead_q   = '0;
    second_q = 1'b0;
    bad_q    = 1'b0;
  endfunction

  // Advance the bench decoder by one transferred byte.
  function automatic void decode_byte(input in_item_t it);
    logic [7:0]      b;
    logic            eos;
    logic [2:0]      extra;
    logic [CP_W-1:0] cp;
    b   = it.byte_in;
    eos = it.end_of_string;
    if (dropping) begin
      if (eos) dropping = 1'b0;
      dropped_bytes++;
      return;
    end
    decoded_bytes++;
    if (need_cnt == 3'd0) begin
      casez (b)
        8'b0???????, 8'b10??????: extra = 3'd0;
        8'b110?????:              extra = 3'd1;
        8'b1110????:              extra = 3'd2;
        8'b11110???:              extra = 3'd3;
        8'b111110??:              extra = 3'd4;
        default:                  extra = 3'd5;
      endcase
      lead_q   = b;
      bad_q    = (b >= CONT_MIN && b < LEAD_MIN) || b > LEAD_MAX || extra > MAX_EXTRA;
      cp_acc   = CP_W'(b & (8'h7F >> extra));
      need_cnt = extra;
      second_q = (extra != 3'd0);
    end else begin
      if (b < CONT_MIN || b > CONT_MAX) bad_q = 1'b1;
      if (second_q) begin
        case (lead_q)
          LEAD_E0: if (b < E0_SECOND_MIN) bad_q = 1'b1;
          LEAD_ED: if (b > ED_SECOND_MAX) bad_q = 1'b1;
          LEAD_F0: if (b < F0_SECOND_MIN) bad_q = 1'b1;
          LEAD_F4: if (b > F4_SECOND_MAX) bad_q = 1'b1;
          default: ;
        endcase
        second_q = 1'b0;
      end
      cp_acc   = {cp_acc[CP_W-7:0], b[5:0]};
      need_cnt = need_cnt - 3'd1;
    end

    if (need_cnt != 3'd0) begin
      // An end flag with the sequence still open beats any failed check.
      if (eos) begin
        reset_sequence();
        expect_result('0, KIND_EXHAUSTED, 1'b1);
      end
      return;
    end
    if (bad_q) begin
      reset_sequence();
      dropping = !eos;
      expect_result('0, KIND_ILLEGAL, 1'b1);
      return;
    end
    cp = cp_acc;
    reset_sequence();
    if (eos) begin
      expect_result(cp, KIND_CODE_POINT, 1'b0);
      expect_result('0, KIND_END_OK, 1'b1);
    end else begin
      expect_result(cp, KIND_CODE_POINT, 1'b1);
    end
  endfunction

  // Transfer detection, prediction and result checking
  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    byte_taken = rst_ni && byte_if.valid && byte_if.ready;
    if (byte_taken) decode_byte(byte_if.payload);
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result cp=%0h kind=%0d last=%0b",
                                  got.code_point, got.kind, got.last_of_run));
      end else begin
        want = due_results.pop_front();
        kind_count[want.kind]++;
        if (got.code_point !== want.code_point)
          report_mismatch($sformatf("code_point %0h, expected %0h",
                                    got.code_point, want.code_point));
        if (got.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %0b, expected %0b (kind %0d)",
                                    got.last_of_run, want.last_of_run, want.kind));
      end
    end
  end

  // Byte driver: hold the item until its transfer, then advance or idle.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
    end else if (!byte_if.valid || byte_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        byte_if.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 19) == 0) begin
        tx_gap = $urandom_range(0, 14);
        byte_if.valid <= 1'b0;
      end else if (byte_stream.size() > 0) begin
        byte_if.valid   <= 1'b1;
        byte_if.payload <= byte_stream.pop_front();
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls plus an occasional long hold-off.
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      rx_hold     = 200;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      res_if.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      res_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 19) == 0) begin
      rx_gap = $urandom_range(0, 14);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eos);
    in_item_t it;
    it.byte_in       = b;
    it.end_of_string = eos;
    byte_stream.push_back(it);
    bytes_queued++;
  endtask

  function automatic int unsigned rand_scalar();
    int unsigned cp;
    case ($urandom_range(0, 3))
      0: cp = $urandom_range(0, 'h7F);
      1: cp = $urandom_range('h80, 'h7FF);
      2: begin
        cp = $urandom_range('h800, 'hFFFF);
        // keep clear of the surrogate block
        if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 'h3000;
      end
      default: cp = $urandom_range('h10000, 'h10FFFF);
    endcase
    return cp;
  endfunction

  function automatic void encode_char(input int unsigned cp, ref logic [7:0] q[$]);
    if (cp < 'h80) begin
      q.push_back(cp[7:0]);
    end else if (cp < 'h800) begin
      q.push_back({3'b110, cp[10:6]});
      q.push_back({2'b10, cp[5:0]});
    end else if (cp < 'h10000) begin
      q.push_back({4'b1110, cp[15:12]});
      q.push_back({2'b10, cp[11:6]});
      q.push_back({2'b10, cp[5:0]});
    end else begin
      q.push_back({5'b11110, cp[20:18]});
      q.push_back({2'b10, cp[17:12]});
      q.push_back({2'b10, cp[11:6]});
      q.push_back({2'b10, cp[5:0]});
    end
  endfunction

  // One string, end flag on its final byte. Mostly legal text.
  task automatic add_random_string();
    logic [7:0]  s[$];
    logic [7:0]  lead;
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      repeat ($urandom_range(1, 6)) encode_char(rand_scalar(), s);
    end else if (pick < 78) begin
      // lead with a limited second byte, second byte anywhere in 80-BF
      if ($urandom_range(0, 1)) encode_char(rand_scalar(), s);
      case ($urandom_range(0, 3))
        0:       lead = LEAD_E0;
        1:       lead = LEAD_ED;
        2:       lead = LEAD_F0;
        default: lead = LEAD_F4;
      endcase
      s.push_back(lead);
      s.push_back({2'b10, 6'($urandom)});
      repeat ((lead >= LEAD_F0) ? 2 : 1) s.push_back({2'b10, 6'($urandom)});
      if ($urandom_range(0, 1)) encode_char(rand_scalar(), s);
    end else if (pick < 87) begin
      // cut the last character short
      repeat ($urandom_range(0, 3)) encode_char(rand_scalar(), s);
      n = s.size();
      encode_char(rand_scalar() | 'h80, s);
      repeat ($urandom_range(1, s.size() - n - 1)) void'(s.pop_back());
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 4)) encode_char(rand_scalar(), s);
      s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
    end else begin
      repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
    end
    foreach (s[i]) push_byte(s[i], i == s.size() - 1);
  endtask

  task automatic fill_phase(input int unsigned target);
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < target) add_random_string();
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    while (byte_stream.size() != 0 || byte_if.valid || due_results.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    rst_ni          = 1'b0;
    byte_if.valid   = 1'b0;
    byte_if.payload = '0;
    res_if.ready    = 1'b0;
    reset_sequence();
    dropping = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, every result kind, the ED limit and the lead and continuation rules
    push_byte(8'h00, 1'b1);                              // smallest byte, end ok
    push_byte(8'h7F, 1'b0);
    push_byte(8'hDF, 1'b0); push_byte(8'hBF, 1'b0);      // largest two-byte value
    push_byte(8'hE0, 1'b0); push_byte(8'hA0, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hED, 1'b0); push_byte(8'hA0, 1'b0);      // ED limit broken, ends string
    push_byte(8'h80, 1'b1);
    push_byte(8'hC0, 1'b0); push_byte(8'hAF, 1'b0);      // overlong lead, start dropping
    push_byte(8'h41, 1'b0);
    push_byte(8'hFF, 1'b1);                              // dropped end byte stops the drop
    push_byte(8'hC2, 1'b0); push_byte(8'h41, 1'b1);      // continuation out of range
    push_byte(8'hF4, 1'b0); push_byte(8'h8F, 1'b0);      // top scalar value
    push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b1);
    push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b1);      // string ends mid-sequence
    push_byte(8'hF8, 1'b1);                              // five-byte lead, exhausted
    wait_drain();

    phase = 0;
    while (bytes_queued < 420) begin
      // receiver stalls long while the sender keeps offering
      if (phase == 1) hold_requests++;
      fill_phase(70);
      wait_drain();
      phase++;
    end

    calm = 1'b1;
    fill_phase(80);
    wait_drain();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);

    $display("Covered %0d bytes: %0d decoded, %0d dropped after illegal sequences.",
             bytes_queued, decoded_bytes, dropped_bytes);
    $display("Checked %0d code points, %0d end-ok, %0d illegal, %0d exhausted.",
             kind_count[KIND_CODE_POINT], kind_count[KIND_END_OK],
             kind_count[KIND_ILLEGAL], kind_count[KIND_EXHAUSTED]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
